FILE: hdl/pee_pkg.sv
// ============================================================================
// pee_pkg: shared types and constants for the postfix expression evaluator
// Holds payload structs, controller states, command/status structs and codes.
// ============================================================================
package pee_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned SpWidth    = $clog2(StackDepth);
  localparam int unsigned CntWidth   = $clog2(StackDepth + 1);
  localparam int unsigned StepWidth  = $clog2(ValueWidth + 1);

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic signed [16:0] SurplusMax = 17'sd65535;
  localparam logic signed [16:0] SurplusMin = -17'sd65536;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrSymbol   = 3'd1,
    ErrDivZero  = 3'd2,
    ErrOperands = 3'd3,
    ErrOperator = 3'd4,
    ErrOverflow = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    OpAdd, OpSub, OpMul, OpDiv, OpPow
  } op_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_present;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StPopA, StPopB, StExec, StWait, StPush, StEmit
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic     load;      // capture accepted item
    logic     pop_a;
    logic     pop_b;
    logic     start;     // start arithmetic
    logic     push_res;
    logic     push_dig;
    logic     set_sym;
    logic     emit;      // form result into output register
    logic     clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_op;
    logic is_digit;
    logic present;
    logic last;
    logic halted;
    logic busy;
    logic out_full;
  } sts_t;

endpackage

FILE: hdl/pee_alu.sv
// ============================================================================
// pee_alu: iterative arithmetic unit
// Add/sub/mul in one step; division by restoring shift-subtract and power by
// square-and-multiply for a non-negative exponent, one bit per cycle.
// ============================================================================
module pee_alu (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  pee_pkg::op_e                          op_i,
  input  logic [pee_pkg::ValueWidth-1:0]        b_i,
  input  logic [pee_pkg::ValueWidth-1:0]        a_i,
  output logic                                  busy_o,
  output logic [pee_pkg::ValueWidth-1:0]        res_o
);
  import pee_pkg::*;

  localparam int unsigned W = ValueWidth;

  logic                 busy_q, busy_d;
  op_e                  op_q, op_d;
  logic [StepWidth-1:0] step_q, step_d;
  logic [W-1:0]         acc_q, acc_d;   // quotient / power result
  logic [W-1:0]         rem_q, rem_d;   // remainder / squared base
  logic [W-1:0]         ex_q, ex_d;     // dividend bits / exponent
  logic [W-1:0]         dv_q, dv_d;     // divisor magnitude
  logic                 neg_q, neg_d;
  logic [W-1:0]         res_q, res_d;

  logic [W-1:0] mag_a, mag_b, prod_ra, prod_bb;
  logic [W:0]   trial;
  logic [W-1:0] rem_sh;

  assign mag_a   = a_i[W-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b   = b_i[W-1] ? (~b_i + 1'b1) : b_i;
  assign rem_sh  = {rem_q[W-2:0], ex_q[W-1]};
  assign trial   = {1'b0, rem_sh} - {1'b0, dv_q};
  assign prod_ra = W'(acc_q * rem_q);
  assign prod_bb = W'(rem_q * rem_q);

  // Sequence one operation
  always_comb begin
    busy_d = busy_q; op_d = op_q; step_d = step_q; acc_d = acc_q; rem_d = rem_q;
    ex_d = ex_q; dv_d = dv_q; neg_d = neg_q; res_d = res_q;
    if (start_i) begin
      op_d = op_i;
      unique case (op_i)
        OpAdd: res_d = b_i + a_i;
        OpSub: res_d = b_i - a_i;
        OpMul: res_d = W'(b_i * a_i);
        OpDiv: begin
          busy_d = 1'b1; step_d = StepWidth'(W); acc_d = '0; rem_d = '0;
          ex_d = mag_b; dv_d = mag_a; neg_d = a_i[W-1] ^ b_i[W-1];
        end
        OpPow: begin
          if (a_i[W-1]) begin
            if (b_i == W'(1)) res_d = W'(1);
            else if (b_i == '1) res_d = a_i[0] ? '1 : W'(1);
            else res_d = '0;
          end else begin
            busy_d = 1'b1; step_d = StepWidth'(W); acc_d = W'(1);
            rem_d = b_i; ex_d = a_i;
          end
        end
        default: res_d = '0;
      endcase
    end else if (busy_q) begin
      step_d = step_q - 1'b1;
      if (op_q == OpDiv) begin
        ex_d = {ex_q[W-2:0], 1'b0};
        if (!trial[W]) begin
          rem_d = trial[W-1:0]; acc_d = {acc_q[W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh; acc_d = {acc_q[W-2:0], 1'b0};
        end
        if (step_q == StepWidth'(1)) begin
          busy_d = 1'b0;
          res_d = neg_q ? (~acc_d + 1'b1) : acc_d;
        end
      end else begin
        if (ex_q[0]) acc_d = prod_ra;
        rem_d = prod_bb;
        ex_d  = ex_q >> 1;
        if (step_q == StepWidth'(1)) begin
          busy_d = 1'b0;
          res_d = acc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; acc_q <= acc_d; rem_q <= rem_d; ex_q <= ex_d;
    dv_q <= dv_d; neg_q <= neg_d; res_q <= res_d;
  end

  assign busy_o = busy_q;
  assign res_o  = res_q;

endmodule

FILE: hdl/pee_datapath.sv
// ============================================================================
// pee_datapath: stack memory, counters, error state and output register
// Executes controller commands; reports item class and unit status.
// ============================================================================
module pee_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pee_pkg::in_item_t  item_i,
  input  pee_pkg::cmd_t      cmd_i,
  output pee_pkg::sts_t      sts_o,
  output pee_pkg::out_item_t out_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import pee_pkg::*;

  localparam int unsigned W = ValueWidth;

  logic [W-1:0]            stack_mem [StackDepth];
  logic [W-1:0]            rd_q;
  in_item_t                item_q;
  logic [CntWidth-1:0]     cnt_q, cnt_d;
  err_e                    err_q, err_d;
  logic signed [16:0]      sur_q, sur_d;
  logic                    und_q, und_d;
  logic [W-1:0]            a_q, b_q;
  logic                    azero_q;
  out_item_t               out_q;
  logic                    ov_q;
  op_e                     op;
  logic                    is_op, is_digit, popping, dig_push, res_push, full;
  logic                    wr_en;
  logic [W-1:0]            alu_res, push_val;
  logic                    alu_busy;
  logic [SpWidth-1:0]      rd_addr;

  assign is_op = item_q.symbol == ChPlus || item_q.symbol == ChMinus ||
                 item_q.symbol == ChStar || item_q.symbol == ChSlash ||
                 item_q.symbol == ChCaret;
  assign is_digit = item_q.symbol >= ChZero && item_q.symbol <= ChNine;

  // Decode operator
  always_comb begin
    unique case (item_q.symbol)
      ChPlus:  op = OpAdd;
      ChMinus: op = OpSub;
      ChStar:  op = OpMul;
      ChSlash: op = OpDiv;
      default: op = OpPow;
    endcase
  end

  pee_alu u_alu (
    .clk_i, .rst_ni, .start_i(cmd_i.start), .op_i(op), .b_i(b_q), .a_i(a_q),
    .busy_o(alu_busy), .res_o(alu_res)
  );

  assign popping  = cmd_i.pop_a | cmd_i.pop_b;
  assign full     = cnt_q == CntWidth'(StackDepth);
  assign dig_push = cmd_i.push_dig;
  assign res_push = cmd_i.push_res;
  assign wr_en    = (dig_push || res_push) && !full;
  // A division by zero pushes zero
  assign push_val = dig_push ? W'(item_q.symbol - ChZero) :
                    (op == OpDiv && azero_q) ? '0 : alu_res;
  // Read the entry that is top of stack after this edge
  assign rd_addr  = SpWidth'(cnt_d - 1'b1);

  // Update counters and errors
  always_comb begin
    cnt_d = cnt_q; err_d = err_q; sur_d = sur_q; und_d = und_q;
    if (cmd_i.load && item_i.symbol_present) begin
      if (item_i.symbol == ChPlus || item_i.symbol == ChMinus ||
          item_i.symbol == ChStar || item_i.symbol == ChSlash ||
          item_i.symbol == ChCaret) begin
        if (sur_q != SurplusMin) sur_d = sur_q - 17'sd1;
      end else if (item_i.symbol >= ChZero && item_i.symbol <= ChNine) begin
        if (sur_q != SurplusMax) sur_d = sur_q + 17'sd1;
      end
    end
    if (popping) begin
      if (cnt_q == '0) und_d = 1'b1;
      else cnt_d = cnt_q - 1'b1;
    end
    if (dig_push || res_push) begin
      if (full) begin
        if (err_q == ErrNone) err_d = ErrOverflow;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
      if (res_push && op == OpDiv && azero_q) err_d = ErrDivZero;
    end
    if (cmd_i.set_sym && err_q == ErrNone) err_d = ErrSymbol;
    if (cmd_i.clear) begin
      cnt_d = '0; err_d = ErrNone; sur_d = '0; und_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; err_q <= ErrNone; sur_q <= '0; und_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; err_q <= err_d; sur_q <= sur_d; und_q <= und_d;
      if (cmd_i.emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  // Stack memory: one write, one registered read at the next top of stack;
  // forward the pushed value when it becomes the top
  always_ff @(posedge clk_i) begin
    if (wr_en) stack_mem[cnt_q[SpWidth-1:0]] <= push_val;
    if (wr_en && rd_addr == cnt_q[SpWidth-1:0]) rd_q <= push_val;
    else rd_q <= stack_mem[rd_addr];
  end

  // Hold item and operands; build result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.pop_a) begin
      a_q     <= (cnt_q == '0) ? '0 : rd_q;
      azero_q <= (cnt_q == '0) || rd_q == '0;
    end
    if (cmd_i.pop_b) b_q <= (cnt_q == '0) ? '0 : rd_q;
    if (cmd_i.emit) begin
      out_q.value <= (cnt_q == '0) ? '0 : 32'(signed'(rd_q));
      if (err_q != ErrNone) out_q.error_code <= err_q;
      else if (und_q || sur_q <= 17'sd0) out_q.error_code <= ErrOperands;
      else if (sur_q > 17'sd1) out_q.error_code <= ErrOperator;
      else out_q.error_code <= ErrNone;
    end
  end

  assign sts_o = '{is_op: is_op, is_digit: is_digit, present: item_q.symbol_present,
                   last: item_q.last, halted: err_q != ErrNone, busy: alu_busy,
                   out_full: ov_q};
  assign out_o       = out_q;
  assign out_valid_o = ov_q;

endmodule

FILE: hdl/pee_ctrl.sv
// ============================================================================
// pee_ctrl: sequencing state machine
// Steps one item through pop, execute, push and result stages.
// ============================================================================
module pee_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pee_pkg::sts_t  sts_i,
  output pee_pkg::cmd_t  cmd_o
);
  import pee_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StPopA;
      StPopA: begin
        if (sts_i.present && sts_i.is_op && !sts_i.halted) state_d = StPopB;
        else state_d = sts_i.last ? StEmit : StIdle;
      end
      StPopB: state_d = StExec;
      StExec: state_d = StWait;
      StWait: if (!sts_i.busy) state_d = StPush;
      StPush: state_d = sts_i.last ? StEmit : StIdle;
      StEmit: if (!sts_i.out_full) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs; the first stage after load also decodes the item
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StPopA: begin
        if (sts_i.present && !sts_i.halted) begin
          cmd_o.pop_a    = sts_i.is_op;
          cmd_o.push_dig = sts_i.is_digit;
          cmd_o.set_sym  = !sts_i.is_op && !sts_i.is_digit;
        end
      end
      StPopB: cmd_o.pop_b = 1'b1;
      StExec: cmd_o.start = 1'b1;
      StWait: ;
      StPush: cmd_o.push_res = 1'b1;
      // Hold until the output register is free
      StEmit: begin
        cmd_o.emit  = !sts_i.out_full;
        cmd_o.clear = !sts_i.out_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

endmodule

FILE: hdl/postfix_expression_evaluator_top.sv
// ============================================================================
// postfix_expression_evaluator_top: single-digit postfix (RPN) evaluator
//
//   channel | direction | signals
//   in      | input     | in_valid_i, in_ready_o, in_item_i
//   out     | output    | out_valid_o, out_ready_i, out_item_o
//
// Operators pop two operands, run the shared arithmetic unit (/, and ^ with a
// non-negative exponent, at one bit per cycle) and push the result; digits
// push directly. The last item then forms the result once an earlier one has
// left the output register. Reset clears counts and errors; stack contents
// are not cleared. Input is accepted only while no item is in progress.
// ============================================================================
module postfix_expression_evaluator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pee_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pee_pkg::out_item_t out_item_o
);
  import pee_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pee_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  pee_datapath u_dp (
    .clk_i, .rst_ni, .item_i(in_item_i), .cmd_i(cmd), .sts_o(sts),
    .out_o(out_item_o), .out_valid_o, .out_ready_i
  );

endmodule

FILE: tb/postfix_expression_evaluator_top_test.sv
// ============================================================================
// Postfix evaluator testbench
// Drives postfix expressions one character per beat and checks each emitted
// value and error code against a built-in predictor. A directed table comes
// first, then random expressions under several ready/valid idling mixes.
// ============================================================================
`timescale 1ns / 100ps

module postfix_expression_evaluator_top_test;
  import pee_pkg::*;

  localparam int Depth = 16;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  postfix_expression_evaluator_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state
  logic [31:0]        calc_stack [Depth];
  int                 calc_count;
  err_e               calc_halt;
  int                 calc_surplus;
  bit                 calc_underflow;
  out_item_t          result_queue[$];
  int                 fail_count;
  int                 result_count;
  int                 beat_count;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  bit                 recv_hold;

  function automatic void calc_clear();
    calc_count = 0;
    calc_halt = ErrNone;
    calc_surplus = 0;
    calc_underflow = 1'b0;
  endfunction

  function automatic logic [31:0] calc_pop();
    if (calc_count == 0) begin
      calc_underflow = 1'b1;
      return '0;
    end
    calc_count--;
    return calc_stack[calc_count];
  endfunction

  function automatic void calc_push(logic [31:0] v);
    if (calc_count >= Depth) begin
      if (calc_halt == ErrNone) calc_halt = ErrOverflow;
      return;
    end
    calc_stack[calc_count] = v;
    calc_count++;
  endfunction

  function automatic void bump(int d);
    calc_surplus += d;
    if (calc_surplus > 65535) calc_surplus = 65535;
    if (calc_surplus < -65536) calc_surplus = -65536;
  endfunction

  function automatic logic [31:0] int_power(logic [31:0] b, logic [31:0] e);
    logic [31:0] r;
    logic [31:0] sq;
    r = 1;
    sq = b;
    if (e[31]) begin
      if (b == 32'd1) return 1;
      if (b == '1) return e[0] ? '1 : 32'd1;
      return 0;
    end
    while (e != 0) begin
      if (e[0]) r = r * sq;
      sq = sq * sq;
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] int_quot(logic [31:0] b, logic [31:0] a);
    logic [31:0] mb;
    logic [31:0] ma;
    logic [31:0] q;
    mb = b[31] ? -b : b;
    ma = a[31] ? -a : a;
    q = mb / ma;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Advance the predictor by one accepted beat
  function automatic void calc_step(in_item_t it);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    out_item_t   res;
    bit          is_op;
    is_op = it.symbol inside {ChPlus, ChMinus, ChStar, ChSlash, ChCaret};
    if (it.symbol_present) begin
      if (is_op) begin
        bump(-1);
        if (calc_halt == ErrNone) begin
          a = calc_pop();
          b = calc_pop();
          case (it.symbol)
            ChPlus:  r = b + a;
            ChMinus: r = b - a;
            ChStar:  r = b * a;
            ChSlash: r = (a != 0) ? int_quot(b, a) : 32'd0;
            default: r = int_power(b, a);
          endcase
          calc_push(r);
          if (it.symbol == ChSlash && a == 0) calc_halt = ErrDivZero;
        end
      end else if (it.symbol >= ChZero && it.symbol <= ChNine) begin
        bump(1);
        if (calc_halt == ErrNone) calc_push(32'(it.symbol - ChZero));
      end else if (calc_halt == ErrNone) begin
        calc_halt = ErrSymbol;
      end
    end
    if (!it.last) return;
    res.value = (calc_count > 0) ? calc_stack[calc_count - 1] : 32'd0;
    if (calc_halt != ErrNone) res.error_code = calc_halt;
    else if (calc_underflow || calc_surplus <= 0) res.error_code = ErrOperands;
    else if (calc_surplus > 1) res.error_code = ErrOperator;
    else res.error_code = ErrNone;
    result_queue.push_back(res);
    calc_clear();
  endfunction

  // Send one beat; hold valid and payload until accepted. Valid stays high
  // after the beat so that a following beat can go out back to back.
  task automatic send_char(logic [7:0] ch, bit present, bit lst);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= '{symbol: ch, symbol_present: present, last: lst};
    do @(posedge clk_i); while (!in_ready_o);
    calc_step(in_item_i);
    beat_count++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b1, i == s.len() - 1);
  endtask

  // Drop valid and drain the result queue
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (result_queue.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: randomly idle, or hold off while recv_hold is set
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      result_count++;
      if (result_queue.size() == 0) begin
        $error("unexpected result value=%0d err=%0d", out_item_o.value,
               out_item_o.error_code);
        fail_count++;
      end else begin
        if (out_item_o.value !== result_queue[0].value) begin
          $error("value: expected %0d, got %0d", $signed(result_queue[0].value),
                 $signed(out_item_o.value));
          fail_count++;
        end
        if (out_item_o.error_code !== result_queue[0].error_code) begin
          $error("error_code: expected %0d, got %0d", result_queue[0].error_code,
                 out_item_o.error_code);
          fail_count++;
        end
        void'(result_queue.pop_front());
      end
    end
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Directed table: string, and whether the typed-in result applies
  typedef struct {
    string     expr;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{"5", 1, '{32'sd5, ErrNone}},
    '{"9", 1, '{32'sd9, ErrNone}},
    '{"0", 1, '{32'sd0, ErrNone}},
    '{"34+", 1, '{32'sd7, ErrNone}},
    '{"35-", 1, '{-32'sd2, ErrNone}},
    '{"99*", 1, '{32'sd81, ErrNone}},
    '{"72/", 1, '{32'sd3, ErrNone}},
    '{"50/", 1, '{32'sd0, ErrDivZero}},
    '{"23^", 1, '{32'sd8, ErrNone}},
    '{"20^", 1, '{32'sd1, ErrNone}},
    '{"203-^", 1, '{32'sd0, ErrNone}},
    '{"01-03-^", 1, '{-32'sd1, ErrNone}},
    '{"102-^", 1, '{32'sd1, ErrNone}},
    '{"5a", 1, '{32'sd5, ErrSymbol}},
    '{"+", 1, '{32'sd0, ErrOperands}},
    '{"3+", 1, '{32'sd3, ErrOperands}},
    '{"12", 1, '{32'sd2, ErrOperator}},
    '{"11111111111111111", 1, '{32'sd1, ErrOverflow}},
    '{"99999999^^^^^^^", 0, '{32'sd0, ErrNone}},
    '{"09-9999999*******2/", 0, '{32'sd0, ErrNone}},
    '{"\xff\x80", 1, '{32'sd0, ErrSymbol}}
  };

  function automatic logic [7:0] rand_char();
    int k;
    k = $urandom_range(99);
    if (k < 55) return ChZero + 8'($urandom_range(9));
    if (k < 95) begin
      case ($urandom_range(4))
        0: return ChPlus;
        1: return ChMinus;
        2: return ChStar;
        3: return ChSlash;
        default: return ChCaret;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed expression with random content, or noise
  task automatic send_random_expr();
    int depth;
    int len;
    logic [7:0] ch;
    len = $urandom_range(1, 12);
    depth = 0;
    if ($urandom_range(9) < 7) begin
      for (int i = 0; i < len; i++) begin
        if (depth >= 2 && ($urandom_range(1) || depth >= 14)) begin
          ch = rand_char();
          if (ch >= ChZero && ch <= ChNine) ch = ChPlus;
          depth--;
        end else begin
          ch = ChZero + 8'($urandom_range(9));
          depth++;
        end
        send_char(ch, 1'b1, 1'b0);
      end
      while (depth > 1) begin
        send_char(ChMinus + 8'($urandom_range(1)) * 8'h31, 1'b1, 1'b0);
        depth--;
      end
      send_char(rand_char(), $urandom_range(3) != 0, 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        send_char(rand_char(), $urandom_range(7) != 0, i == len - 1);
      end
    end
  endtask

  // Main stimulus
  initial begin
    int stall;
    calc_clear();
    fail_count = 0;
    result_count = 0;
    beat_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: typed rows also checked against the table value
    foreach (dir_rows[i]) begin
      send_string(dir_rows[i].expr);
      if (dir_rows[i].typed && result_queue[$] != dir_rows[i].want) begin
        $error("table row %0d: predictor gives %0d/%0d", i,
               $signed(result_queue[$].value), result_queue[$].error_code);
        fail_count++;
      end
    end
    send_char(8'h00, 1'b0, 1'b1);
    send_char(8'hFF, 1'b0, 1'b1);

    // Random part under three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 51 : 0;
      recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 21 : 0;
      if (ph == 1) begin
        // Sender pauses until all results are in
        wait_drained();
      end
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering beats
        recv_hold = 1'b1;
        fork
          begin
            stall = 0;
            while (stall < 400) begin
              @(posedge clk_i);
              stall++;
            end
            recv_hold = 1'b0;
          end
          repeat (6) send_random_expr();
        join
      end
      while (beat_count < 300 + (ph + 1) * 540) send_random_expr();
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d beats, checked %0d results across three idling mixes.",
             beat_count, result_count);
    if (fail_count == 0 && result_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hdl/pee_pkg.sv
hdl/pee_alu.sv
hdl/pee_datapath.sv
hdl/pee_ctrl.sv
hdl/postfix_expression_evaluator_top.sv
tb/postfix_expression_evaluator_top_test.sv
